// File: hw/rtl/hpj_pkg.sv
// ============================================================================
// hpj_pkg: shared definitions of the heated plate Jacobi stencil
// Sizes, field widths, register indexes, reset values, the result word and
// the grid size clamps used by the stencil datapath.
// ============================================================================
`default_nettype none

package hpj_pkg;

	// Largest plate the line stores are sized for (interior cells).
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;

	// One line store row holds the interior cells plus both boundary cells.
	localparam int LINE_LEN = MAX_COLS + 2;
	localparam int LINE_AW  = $clog2(LINE_LEN);

	// Field widths fixed by the interface.
	localparam int VAL_W = 18;
	localparam int IDX_W = 11;
	localparam int SUM_W = VAL_W + 2;

	// Position counters: a column runs to MAX_COLS+1, a row to MAX_ROWS+2.
	localparam int COL_W = $clog2(MAX_COLS + 2);
	localparam int ROW_W = $clog2(MAX_ROWS + 3);

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = VAL_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_COLS     = 3'd0,
		REG_GRID_ROWS     = 3'd1,
		REG_HOTSPOT_EN    = 3'd2,
		REG_HOTSPOT_ROW   = 3'd3,
		REG_HOTSPOT_COL   = 3'd4,
		REG_HOTSPOT_VALUE = 3'd5
	} cfg_reg_t;

	localparam logic [IDX_W-1:0] RST_GRID_COLS     = IDX_W'(1024);
	localparam logic [IDX_W-1:0] RST_GRID_ROWS     = IDX_W'(1024);
	localparam logic             RST_HOTSPOT_EN    = 1'b0;
	localparam logic [IDX_W-1:0] RST_HOTSPOT_ROW   = IDX_W'(1);
	localparam logic [IDX_W-1:0] RST_HOTSPOT_COL   = IDX_W'(1);
	localparam logic [VAL_W-1:0] RST_HOTSPOT_VALUE = VAL_W'(256000);

	// One result word of the output channel.
	typedef struct packed {
		logic [VAL_W-1:0] new_value;
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
		logic             last_cell;
	} result_t;

	// A zero size counts as one; a size past the line store is cut to it.
	function automatic logic [COL_W-1:0] clamp_cols(input logic [IDX_W-1:0] v);
		if (v == '0) begin
			return COL_W'(1);
		end else if (int'(v) > MAX_COLS) begin
			return COL_W'(MAX_COLS);
		end else begin
			return COL_W'(v);
		end
	endfunction

	function automatic logic [ROW_W-1:0] clamp_rows(input logic [IDX_W-1:0] v);
		if (v == '0) begin
			return ROW_W'(1);
		end else if (int'(v) > MAX_ROWS) begin
			return ROW_W'(MAX_ROWS);
		end else begin
			return ROW_W'(v);
		end
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/heat_plate_jacobi_stencil.sv
// ============================================================================
// heat_plate_jacobi_stencil: streaming Jacobi 4-point sweep of a heated plate
// Takes grid cells in raster order, boundary ring included, and gives the
// next-sweep value of every interior cell, with an optional forced hot spot.
// ============================================================================
// The block accepts one grid word per clock while the skid word is free, and
// a result word enters the output stage when the cell below an interior cell
// is accepted. The rate is set by the two line-store RAMs: each has two read
// ports addressed one cell ahead from the position counters, so the three
// neighbours of the upper row pair are ready the moment the next cell comes
// in, and the cell itself is written in the same clock. A result goes into a
// two-word output stage; the input stalls only when both words are held by a
// stalled output. Words with no result (boundary cells, cells past the end of
// a pass) are taken even while the output stalls, as long as the skid word is
// free. Mark the first cell of every pass with grid_start. The line stores
// are not cleared after reset; they need no clearing pass, since a normal
// pass reads only entries that it wrote itself. Write configuration only
// while no results are pending.
`default_nettype none

module heat_plate_jacobi_stencil (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input grid words.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [hpj_pkg::VAL_W-1:0]      cell_value,
	input  logic                           grid_start,
	// Result words.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [hpj_pkg::VAL_W-1:0]      new_value,
	output logic [hpj_pkg::IDX_W-1:0]      out_row,
	output logic [hpj_pkg::IDX_W-1:0]      out_col,
	output logic                           last_cell,
	// Configuration writes.
	input  logic                           cfg_write,
	input  logic [hpj_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hpj_pkg::CFG_DATA_W-1:0] cfg_data
);

	import hpj_pkg::*;

	// Configuration registers.
	logic [IDX_W-1:0] grid_cols_q;
	logic [IDX_W-1:0] grid_rows_q;
	logic             hot_en_q;
	logic [IDX_W-1:0] hot_row_q;
	logic [IDX_W-1:0] hot_col_q;
	logic [VAL_W-1:0] hot_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= RST_GRID_COLS;
			grid_rows_q <= RST_GRID_ROWS;
			hot_en_q    <= RST_HOTSPOT_EN;
			hot_row_q   <= RST_HOTSPOT_ROW;
			hot_col_q   <= RST_HOTSPOT_COL;
			hot_val_q   <= RST_HOTSPOT_VALUE;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GRID_COLS:     grid_cols_q <= cfg_data[IDX_W-1:0];
				REG_GRID_ROWS:     grid_rows_q <= cfg_data[IDX_W-1:0];
				REG_HOTSPOT_EN:    hot_en_q    <= cfg_data[0];
				REG_HOTSPOT_ROW:   hot_row_q   <= cfg_data[IDX_W-1:0];
				REG_HOTSPOT_COL:   hot_col_q   <= cfg_data[IDX_W-1:0];
				REG_HOTSPOT_VALUE: hot_val_q   <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Sizes in use, with zero taken as one and oversize cut to the store.
	logic [COL_W-1:0] cols;
	logic [ROW_W-1:0] rows;
	logic [ROW_W-1:0] rows_p1;

	assign cols    = clamp_cols(grid_cols_q);
	assign rows    = clamp_rows(grid_rows_q);
	assign rows_p1 = rows + ROW_W'(1);

	// Position of the next cell expected on the input.
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic             accept;
	logic [ROW_W-1:0] cur_r;
	logic [COL_W-1:0] cur_c;
	logic             past_end;
	logic [ROW_W-1:0] next_r;
	logic [COL_W-1:0] next_c;
	logic [ROW_W-1:0] pos_r;
	logic [COL_W-1:0] pos_c;

	assign accept = in_valid && !in_stall;

	// A start mark puts the incoming cell at the top left corner.
	assign cur_r = grid_start ? '0 : row_q;
	assign cur_c = grid_start ? '0 : col_q;

	// Cells after the last boundary row of a pass are swallowed.
	assign past_end = cur_r > rows_p1;

	always_comb begin
		if (past_end) begin
			next_r = cur_r;
			next_c = cur_c;
		end else if (cur_c > cols) begin
			next_r = cur_r + ROW_W'(1);
			next_c = '0;
		end else begin
			next_r = cur_r;
			next_c = cur_c + COL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= next_r;
			col_q <= next_c;
		end
	end

	// The line stores are read for the position of the cell that comes next,
	// so their registered data lines up with it when it is accepted. A start
	// mark on that cell moves it to row zero, where no neighbours are needed.
	assign pos_r = accept ? next_r : row_q;
	assign pos_c = accept ? next_c : col_q;

	logic [LINE_AW-1:0] addr_c;
	logic [LINE_AW-1:0] addr_m1;
	logic [LINE_AW-1:0] addr_p1;

	assign addr_c  = LINE_AW'(pos_c);
	assign addr_m1 = LINE_AW'(pos_c - COL_W'(1));
	assign addr_p1 = LINE_AW'(pos_c + COL_W'(1));

	// Line k holds the rows whose parity is k. The line of the current row
	// still holds the row two above: its port a gives the upper neighbour.
	// The other line holds the row just above: its ports give left and right.
	logic [VAL_W-1:0] rdata_a [2];
	logic [VAL_W-1:0] rdata_b [2];

	for (genvar k = 0; k < 2; k++) begin : g_line
		logic we_line;
		logic [LINE_AW-1:0] raddr_a_line;

		assign we_line      = accept && !past_end && (cur_r[0] == 1'(k));
		assign raddr_a_line = (pos_r[0] == 1'(k)) ? addr_c : addr_m1;

		hpj_ram #(
			.WIDTH (VAL_W),
			.DEPTH (LINE_LEN)
		) u_line (
			.clk     (clk),
			.we      (we_line),
			.waddr   (LINE_AW'(cur_c)),
			.wdata   (cell_value),
			.raddr_a (raddr_a_line),
			.raddr_b (addr_p1),
			.rdata_a (rdata_a[k]),
			.rdata_b (rdata_b[k])
		);
	end

	// Stencil: the cell just accepted is the lower neighbour.
	logic [VAL_W-1:0] up_val;
	logic [VAL_W-1:0] left_val;
	logic [VAL_W-1:0] right_val;
	logic [SUM_W-1:0] sum;
	logic [ROW_W-1:0] orow;
	logic             has_out;
	logic             hot_hit;
	logic             res_valid;
	result_t          res;
	result_t          out_res;

	assign up_val    = cur_r[0] ? rdata_a[1] : rdata_a[0];
	assign left_val  = cur_r[0] ? rdata_a[0] : rdata_a[1];
	assign right_val = cur_r[0] ? rdata_b[0] : rdata_b[1];

	assign sum = SUM_W'(left_val) + SUM_W'(right_val) + SUM_W'(up_val)
		+ SUM_W'(cell_value);

	assign orow    = cur_r - ROW_W'(1);
	assign has_out = !past_end && (cur_r >= ROW_W'(2)) && (cur_c != '0)
		&& (cur_c <= cols);
	assign hot_hit = hot_en_q && (int'(orow) == int'(hot_row_q))
		&& (int'(cur_c) == int'(hot_col_q));

	assign res_valid     = accept && has_out;
	assign res.new_value = hot_hit ? hot_val_q : sum[SUM_W-1:2];
	assign res.out_row   = IDX_W'(orow);
	assign res.out_col   = IDX_W'(cur_c);
	assign res.last_cell = (orow == rows) && (cur_c == cols);

	hpj_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.full      (in_stall)
	);

	assign new_value = out_res.new_value;
	assign out_row   = out_res.out_row;
	assign out_col   = out_res.out_col;
	assign last_cell = out_res.last_cell;

	// The skid word only fills behind a held output word.
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty output register");

	// The column counter never runs past the right boundary of the store.
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) <= MAX_COLS + 1)
		else $error("column counter past the line store");

	// A start mark always leaves the counters just right of the corner.
	a_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && grid_start) |=> (row_q == '0 && col_q == COL_W'(1)))
		else $error("start mark did not restart the position counters");

endmodule

`default_nettype wire

// File: hw/rtl/hpj_ram.sv
// ============================================================================
// hpj_ram: generic RAM with one write port and two registered read ports
// Read data appears the clock after the address; a read of the address being
// written returns the old contents.
// ============================================================================
`default_nettype none

module hpj_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1026
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// File: hw/rtl/hpj_out_buf.sv
// ============================================================================
// hpj_out_buf: two-entry output stage of the stencil
// An output register plus a skid register, so a result can be taken in while
// the one in front is stalled.
// ============================================================================
`default_nettype none

module hpj_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  hpj_pkg::result_t res,
	output logic             out_valid,
	input  logic             out_stall,
	output hpj_pkg::result_t out_res,
	output logic             full
);

	import hpj_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    load_out;

	// The output register may take a new word when empty or being taken now.
	assign load_out = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (!load_out && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign full      = skid_valid_q;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ============================================================================
// testbench: self-checking bench for the heated plate Jacobi stencil
// Streams raster-order plates through the block with random gaps on both
// sides. An in-bench model of the sweep works out each next-sweep word, and
// every result word that comes out is checked against the oldest one due.
// ============================================================================
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hpj_pkg::*;

	localparam logic [VAL_W-1:0] VAL_MAX   = '1;
	localparam int               IDLE_STOP = 2000;

	// Model of one sweep: line stores, raster position, register copies and
	// the queue of result words that the block still owes.
	class sweep_ledger;
		logic [VAL_W-1:0] line_mem [2][LINE_LEN];
		int unsigned      row_pos;
		int unsigned      col_pos;
		logic [IDX_W-1:0] cols_reg;
		logic [IDX_W-1:0] rows_reg;
		logic             spot_on;
		logic [IDX_W-1:0] spot_row;
		logic [IDX_W-1:0] spot_col;
		logic [VAL_W-1:0] spot_temp;
		result_t          due_words[$];
		int               errors;

		function new();
			foreach (line_mem[i, j]) line_mem[i][j] = '0;
			row_pos   = 0;
			col_pos   = 0;
			cols_reg  = RST_GRID_COLS;
			rows_reg  = RST_GRID_ROWS;
			spot_on   = RST_HOTSPOT_EN;
			spot_row  = RST_HOTSPOT_ROW;
			spot_col  = RST_HOTSPOT_COL;
			spot_temp = RST_HOTSPOT_VALUE;
			errors    = 0;
		endfunction

		function int unsigned fit(logic [IDX_W-1:0] v, int unsigned top);
			if (v == 0) return 1;
			if (v > top) return top;
			return v;
		endfunction

		function int unsigned cols_in_use();
			return fit(cols_reg, MAX_COLS);
		endfunction

		function int unsigned rows_in_use();
			return fit(rows_reg, MAX_ROWS);
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GRID_COLS:     cols_reg  = data[IDX_W-1:0];
				REG_GRID_ROWS:     rows_reg  = data[IDX_W-1:0];
				REG_HOTSPOT_EN:    spot_on   = data[0];
				REG_HOTSPOT_ROW:   spot_row  = data[IDX_W-1:0];
				REG_HOTSPOT_COL:   spot_col  = data[IDX_W-1:0];
				REG_HOTSPOT_VALUE: spot_temp = data[VAL_W-1:0];
				default: ;
			endcase
		endfunction

		// One accepted grid word: the cell below an interior cell completes
		// that cell's four-point average.
		function void take_cell(logic [VAL_W-1:0] cell_val, logic start);
			int unsigned cols, rows, r, c, left, right, up, sum;
			result_t     w;
			cols = cols_in_use();
			rows = rows_in_use();
			if (start) begin
				row_pos = 0;
				col_pos = 0;
			end
			r = row_pos;
			c = col_pos;
			if (r > rows + 1) return;
			if (r >= 2 && c >= 1 && c <= cols) begin
				left  = line_mem[(r - 1) % 2][c - 1];
				right = (c + 1 < LINE_LEN) ? line_mem[(r - 1) % 2][c + 1] : 0;
				up    = line_mem[r % 2][c];
				sum   = left + right + up + cell_val;
				w.new_value = VAL_W'(sum >> 2);
				if (spot_on && (r - 1) == spot_row && c == spot_col)
					w.new_value = spot_temp;
				w.out_row   = IDX_W'(r - 1);
				w.out_col   = IDX_W'(c);
				w.last_cell = ((r - 1) == rows && c == cols);
				due_words.push_back(w);
			end
			if (c < LINE_LEN) line_mem[r % 2][c] = cell_val;
			if (c >= cols + 1) begin
				col_pos = 0;
				row_pos = r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("mismatch: %s", msg);
		endfunction

		function void match_result(result_t got);
			result_t w;
			if (due_words.size() == 0) begin
				flag($sformatf("expected no word, got value=%0d row=%0d col=%0d last=%0d",
				               got.new_value, got.out_row, got.out_col, got.last_cell));
				return;
			end
			w = due_words.pop_front();
			if (got.new_value !== w.new_value || got.out_row !== w.out_row ||
			    got.out_col !== w.out_col || got.last_cell !== w.last_cell)
				flag($sformatf("expected value=%0d row=%0d col=%0d last=%0d, got %0d %0d %0d %0d",
				               w.new_value, w.out_row, w.out_col, w.last_cell,
				               got.new_value, got.out_row, got.out_col, got.last_cell));
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		function void close_out();
			result_t w;
			while (due_words.size() > 0) begin
				w = due_words.pop_front();
				flag($sformatf("expected value=%0d row=%0d col=%0d last=%0d, got no word",
				               w.new_value, w.out_row, w.out_col, w.last_cell));
			end
		endfunction
	endclass

	// Every input of the block starts from a known value.
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [VAL_W-1:0]      cell_value = '0;
	logic                  grid_start = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b1;
	logic [VAL_W-1:0]      new_value;
	logic [IDX_W-1:0]      out_row;
	logic [IDX_W-1:0]      out_col;
	logic                  last_cell;
	logic                  cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	sweep_ledger board = new();
	int          send_calm = 0;
	int          take_calm = 0;
	int          cells_sent = 0;

	heat_plate_jacobi_stencil dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_value (cell_value),
		.grid_start (grid_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.new_value  (new_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.last_cell  (last_cell),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Each side draws a random wait before every word, except during calm
	// stretches in which it runs flat out so back-to-back traffic is seen too.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	// Mostly random temperatures, with the zero and full-scale corners mixed in.
	function automatic logic [VAL_W-1:0] pick_temp();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return VAL_MAX;
			default: return VAL_W'($urandom_range(0, VAL_MAX));
		endcase
	endfunction

	// Register data carries random bits above the register width; the block
	// must ignore them.
	function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned v, int w);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		if (w < CFG_DATA_W) d = (d << w) | CFG_DATA_W'(v);
		else d = CFG_DATA_W'(v);
		return d;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// The caller makes sure the block is idle; write enable stays high across
	// the six back-to-back writes and drops once at the end.
	task automatic set_plate(input int unsigned cols, input int unsigned rows,
	                         input int unsigned en, input int unsigned spot_r,
	                         input int unsigned spot_c, input int unsigned temp);
		write_reg(REG_GRID_COLS, with_junk(cols, IDX_W));
		write_reg(REG_GRID_ROWS, with_junk(rows, IDX_W));
		write_reg(REG_HOTSPOT_EN, with_junk(en, 1));
		write_reg(REG_HOTSPOT_ROW, with_junk(spot_r, IDX_W));
		write_reg(REG_HOTSPOT_COL, with_junk(spot_c, IDX_W));
		write_reg(REG_HOTSPOT_VALUE, with_junk(temp, VAL_W));
		cfg_write <= 1'b0;
	endtask

	// Offer one grid word and hold it until the block takes it. Stall is
	// sampled right after the edge, so it is the value the edge saw.
	task automatic push_cell(input logic [VAL_W-1:0] v, input logic s);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cell_value <= v;
		grid_start <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.take_cell(v, s);
	endtask

	// One raster pass over the plate in use, boundary ring included. A
	// positive cut stops the pass early; the next pass restarts it.
	task automatic send_pass(input int cut);
		int total;
		total = (board.rows_in_use() + 2) * (board.cols_in_use() + 2);
		for (int i = 0; i < total && (cut <= 0 || i < cut); i++) begin
			push_cell(pick_temp(), i == 0);
			cells_sent++;
		end
	endtask

	// Words past the end of a pass must be swallowed without a result.
	task automatic send_tail(input int n);
		for (int i = 0; i < n; i++) push_cell(pick_temp(), 1'b0);
	endtask

	// Wait for every owed word, then let the clock run on in case the block is
	// still busy with words that give no result, before touching registers.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic int unsigned pick_size();
		if ($urandom_range(0, 19) == 0) return 0;
		return $urandom_range(1, 6);
	endfunction

	// Hot spot index: half the time inside the plate, else just past it, at zero
	// or at the top of the field, where it must never match.
	function automatic int unsigned pick_spot(int unsigned span);
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 2047;
			2:       return span + 1;
			default: return $urandom_range(1, span);
		endcase
	endfunction

	task automatic random_phase();
		int unsigned cols, rows;
		int          passes, total;
		cols = pick_size();
		rows = pick_size();
		set_plate(cols, rows, $urandom_range(0, 1),
		          pick_spot(rows == 0 ? 1 : rows), pick_spot(cols == 0 ? 1 : cols),
		          pick_temp());
		passes = $urandom_range(1, 3);
		for (int p = 0; p < passes; p++) begin
			total = (board.rows_in_use() + 2) * (board.cols_in_use() + 2);
			if ($urandom_range(0, 4) == 0) begin
				send_pass($urandom_range(1, total - 1));
			end else begin
				send_pass(0);
				if ($urandom_range(0, 3) == 0) send_tail($urandom_range(1, 3));
			end
		end
		settle();
	endtask

	// Result side: stall for a drawn number of cycles, then take the next word
	// and check it against the oldest expectation.
	initial begin
		result_t got;
		int      gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_wait(take_calm);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.new_value = new_value;
			got.out_row   = out_row;
			got.out_col   = out_col;
			got.last_cell = last_cell;
			board.match_result(got);
		end
	end

	// Watchdog: too many cycles without any word moving on either side, and
	// without a register write, means the block has hung.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_STOP) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a 2x2 plate with the hot spot at row 1, column 2
		// forced to full scale, corner temperatures mostly, two words past
		// the end of the pass, then a pass cut short to be restarted later.
		set_plate(2, 2, 1, 1, 2, VAL_MAX);
		for (int i = 0; i < 16; i++) begin
			case (i % 3)
				0:       push_cell(VAL_MAX, i == 0);
				1:       push_cell('0, 1'b0);
				default: push_cell(pick_temp(), 1'b0);
			endcase
		end
		send_tail(2);
		send_pass(5);
		settle();

		// Random part: small plates with random hot spots, restarts and tails.
		while (cells_sent < 650) random_phase();

		repeat (20) @(posedge clk);
		board.close_out();
		if (board.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
